// ===== src/rpc_pkg.sv =====
// Shared types, constants, microcode program and tap helper of the RST polynomial controller.
`default_nettype none

package rpc_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int ACC_W        = 40;
   localparam int QUO_W        = ACC_W + 1;
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = ACC_W / DIV_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int PC_W         = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_S_COEFS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_T_COEFS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_TAIL_COEFS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_R_LEAD       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HIGH     = 3'd5;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_LOW  = 2'd1,
      CLAMP_HIGH = 2'd2
   } clamp_type;

   typedef enum logic [2:0] {
      CF_T0,
      CF_S0,
      CF_T,
      CF_S,
      CF_R
   } coef_src_type;

   typedef enum logic [2:0] {
      SMP_W,
      SMP_Y,
      SMP_PAST_W,
      SMP_PAST_Y,
      SMP_PAST_U
   } smp_src_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_LOOP,
      JC_DIV
   } jump_cond_type;

   typedef struct packed {
      logic          mac;
      logic          mac_sub;
      coef_src_type  coef_src;
      smp_src_type   smp_src;
      logic          idx_inc;
      logic          div_init;
      logic          div_step;
      logic          finish;
      jump_cond_type cond;
      pc_type        target;
   } ucode_type;

   typedef struct packed {
      logic init;
      logic step;
   } div_ctrl_type;

   localparam pc_type PC_LOOP_TOP = 4'd2;
   localparam pc_type PC_DIV_STEP = 4'd7;

   // The control program. Steps 2 to 4 walk the history taps, step 7 repeats
   // until the divider has produced all quotient digits.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      w          = '0;
      w.coef_src = CF_T0;
      w.smp_src  = SMP_W;
      w.cond     = JC_NONE;
      case (pc)
         4'd0: begin
            w.mac      = 1'b1;
            w.coef_src = CF_T0;
            w.smp_src  = SMP_W;
         end
         4'd1: begin
            w.mac      = 1'b1;
            w.mac_sub  = 1'b1;
            w.coef_src = CF_S0;
            w.smp_src  = SMP_Y;
         end
         4'd2: begin
            w.mac      = 1'b1;
            w.coef_src = CF_T;
            w.smp_src  = SMP_PAST_W;
         end
         4'd3: begin
            w.mac      = 1'b1;
            w.mac_sub  = 1'b1;
            w.coef_src = CF_S;
            w.smp_src  = SMP_PAST_Y;
         end
         4'd4: begin
            w.mac      = 1'b1;
            w.mac_sub  = 1'b1;
            w.coef_src = CF_R;
            w.smp_src  = SMP_PAST_U;
            w.idx_inc  = 1'b1;
            w.cond     = JC_LOOP;
            w.target   = PC_LOOP_TOP;
         end
         4'd5: begin
            // Lets the last product reach the accumulator.
         end
         4'd6: begin
            w.div_init = 1'b1;
         end
         4'd7: begin
            w.div_step = 1'b1;
            w.cond     = JC_DIV;
            w.target   = PC_DIV_STEP;
         end
         4'd8: begin
            w.finish = 1'b1;
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // A coefficient slot of a register packed 16 bits per tap; slot 3 lies past
   // every register and reads as zero.
   function automatic logic signed [SAMPLE_W-1:0] coef_tap(input logic [47:0] packed_coefs,
                                                           input logic [1:0]  slot);
      logic signed [SAMPLE_W-1:0] c;
      case (slot)
         2'd0:    c = packed_coefs[15:0];
         2'd1:    c = packed_coefs[31:16];
         2'd2:    c = packed_coefs[47:32];
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/rpc_if.sv =====
// Handshake channel interfaces of the RST polynomial controller.
`default_nettype none

interface rpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] measurement;
   logic [15:0] setpoint;

   modport source (output valid, output measurement, output setpoint, input ready);
   modport sink   (input valid, input measurement, input setpoint, output ready);
endinterface

interface rpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] control;
   logic [1:0]  clamped;
   logic        divide_error;

   modport source (output valid, output control, output clamped, output divide_error,
                   input ready);
   modport sink   (input valid, input control, input clamped, input divide_error,
                   output ready);
endinterface

interface rpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rst_polynomial_controller_core.sv =====
// Top level of the RST polynomial controller: microcoded sequencer, MAC datapath, histories.
// Each request word runs 2+3*ORDER multiply-accumulate steps, one drain step, one divider
// load, ten divider steps of four bits each and one finish step, which waits until the output
// register is free. The single shared multiplier and the iterative divider allow one word in
// flight; a new request word is taken once the finish step ends, while the previous result still
// waits. Synchronous reset clears the histories, restores the register defaults (r_lead 1.0,
// out_low 0, out_high 5120) and empties the output.
`default_nettype none

module rst_polynomial_controller_core import rpc_pkg::*; #(
   parameter int ORDER = 2
) (
   input  logic       clock,
   input  logic       reset,
   rpc_req_if.sink    req_ch,
   rpc_rsp_if.source  rsp_ch,
   rpc_csr_if.sink    csr_ch
);

   localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;

   // Configuration registers.
   logic [47:0]                s_coefs_ff;
   logic [47:0]                t_coefs_ff;
   logic [31:0]                r_tail_ff;
   logic signed [SAMPLE_W-1:0] r_lead_ff;
   logic signed [SAMPLE_W-1:0] out_low_ff;
   logic signed [SAMPLE_W-1:0] out_high_ff;

   // Sequencer state.
   logic       busy_ff;
   logic       busy_in;
   pc_type     pc_ff;
   pc_type     pc_in;
   logic [IDX_W-1:0] idx_ff;
   ucode_type  uc;
   logic       jump;
   logic       accept;
   logic       out_free;
   logic       fin_go;

   // Datapath.
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [SAMPLE_W-1:0] w_ff;
   logic signed [SAMPLE_W-1:0] past_y_ff [ORDER];
   logic signed [SAMPLE_W-1:0] past_w_ff [ORDER];
   logic signed [SAMPLE_W-1:0] past_u_ff [ORDER];
   logic signed [SAMPLE_W-1:0] coef_mux;
   logic signed [SAMPLE_W-1:0] smp_mux;
   logic [1:0]                 slot_cur;
   logic [1:0]                 slot_next;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       prod_sub_ff;
   logic                       prod_vld_ff;
   logic signed [ACC_W-1:0]    acc_ff;

   div_ctrl_type               div_ctrl;
   logic signed [QUO_W-1:0]    quotient;
   logic                       div_last;

   // Result.
   logic signed [SAMPLE_W-1:0] u_in;
   clamp_type                  clamp_in;
   logic                       derr_in;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_control_ff;
   clamp_type                  rsp_clamp_ff;
   logic                       rsp_derr_ff;

   // Configuration writes; an index past the register list is dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_coefs_ff  <= '0;
         t_coefs_ff  <= '0;
         r_tail_ff   <= '0;
         r_lead_ff   <= 16'sd4096;
         out_low_ff  <= '0;
         out_high_ff <= 16'sd5120;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_S_COEFS:      s_coefs_ff  <= csr_ch.data;
            CSR_T_COEFS:      t_coefs_ff  <= csr_ch.data;
            CSR_R_TAIL_COEFS: r_tail_ff   <= csr_ch.data[31:0];
            CSR_R_LEAD:       r_lead_ff   <= csr_ch.data[15:0];
            CSR_OUT_LOW:      out_low_ff  <= csr_ch.data[15:0];
            CSR_OUT_HIGH:     out_high_ff <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer: the control word at pc drives the datapath, and the jump
   // condition picks between the next step and the word's target.
   assign uc           = ucode_rom(pc_ff);
   assign req_ch.ready = !busy_ff;
   assign accept       = req_ch.valid && !busy_ff;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign fin_go       = busy_ff && uc.finish && out_free;

   always_comb begin
      case (uc.cond)
         JC_NONE: jump = 1'b0;
         JC_LOOP: jump = (idx_ff != IDX_W'(ORDER - 1));
         JC_DIV:  jump = !div_last;
         default: jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (accept) begin
         pc_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (uc.finish) begin
            // The finish step waits here until the output register is free.
            if (out_free) begin
               busy_in = 1'b0;
            end
         end else begin
            pc_in = jump ? uc.target : pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         if (accept) begin
            idx_ff <= '0;
         end else if (busy_ff && uc.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         y_ff <= req_ch.measurement;
         w_ff <= req_ch.setpoint;
      end
   end

   // Operand selection. T and S taps of history entry i use slot i+1, the R
   // tail uses slot i since r0 is the divisor.
   assign slot_cur  = 2'(idx_ff);
   assign slot_next = 2'(idx_ff) + 2'd1;

   always_comb begin
      case (uc.coef_src)
         CF_T0:   coef_mux = coef_tap(t_coefs_ff, 2'd0);
         CF_S0:   coef_mux = coef_tap(s_coefs_ff, 2'd0);
         CF_T:    coef_mux = coef_tap(t_coefs_ff, slot_next);
         CF_S:    coef_mux = coef_tap(s_coefs_ff, slot_next);
         CF_R:    coef_mux = coef_tap({16'b0, r_tail_ff}, slot_cur);
         default: coef_mux = '0;
      endcase
   end

   always_comb begin
      case (uc.smp_src)
         SMP_W:      smp_mux = w_ff;
         SMP_Y:      smp_mux = y_ff;
         SMP_PAST_W: smp_mux = past_w_ff[idx_ff];
         SMP_PAST_Y: smp_mux = past_y_ff[idx_ff];
         SMP_PAST_U: smp_mux = past_u_ff[idx_ff];
         default:    smp_mux = '0;
      endcase
   end

   // The product is registered, then added into the accumulator in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= busy_ff && uc.mac;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && uc.mac) begin
         prod_ff     <= coef_mux * smp_mux;
         prod_sub_ff <= uc.mac_sub;
      end
      if (accept) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= prod_sub_ff ? acc_ff - ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      end
   end

   assign div_ctrl.init = busy_ff && uc.div_init;
   assign div_ctrl.step = busy_ff && uc.div_step;

   rpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (acc_ff),
      .divisor  (r_lead_ff),
      .quotient (quotient),
      .last     (div_last)
   );

   // Zero divisor gives 0 with the error flag; otherwise the low limit is
   // tested before the high one, which matters when the limits are crossed.
   always_comb begin
      u_in     = quotient[SAMPLE_W-1:0];
      clamp_in = CLAMP_NONE;
      derr_in  = 1'b0;
      if (r_lead_ff == '0) begin
         u_in    = '0;
         derr_in = 1'b1;
      end else if (quotient < QUO_W'(out_low_ff)) begin
         u_in     = out_low_ff;
         clamp_in = CLAMP_LOW;
      end else if (quotient > QUO_W'(out_high_ff)) begin
         u_in     = out_high_ff;
         clamp_in = CLAMP_HIGH;
      end
   end

   // Histories shift when the result is committed.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER; k++) begin
            past_y_ff[k] <= '0;
            past_w_ff[k] <= '0;
            past_u_ff[k] <= '0;
         end
      end else if (fin_go) begin
         for (int k = ORDER - 1; k > 0; k--) begin
            past_y_ff[k] <= past_y_ff[k-1];
            past_w_ff[k] <= past_w_ff[k-1];
            past_u_ff[k] <= past_u_ff[k-1];
         end
         past_y_ff[0] <= y_ff;
         past_w_ff[0] <= w_ff;
         past_u_ff[0] <= u_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_control_ff <= u_in;
         rsp_clamp_ff   <= clamp_in;
         rsp_derr_ff    <= derr_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.control      = rsp_control_ff;
   assign rsp_ch.clamped      = rsp_clamp_ff;
   assign rsp_ch.divide_error = rsp_derr_ff;

   // A new result only comes out of the finish step of a running item.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && $past(uc.finish))
      else $error("result word appeared without a finishing item");

   // Ending an item always leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && !$past(reset) |-> rsp_valid_ff)
      else $error("item ended without a result word");

   // A division error reports zero and no clamping.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_derr_ff |-> rsp_control_ff == '0 && rsp_clamp_ff == CLAMP_NONE)
      else $error("division error with nonzero control");

   // A value clamped high carries the high limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_clamp_ff == CLAMP_HIGH |-> rsp_control_ff == out_high_ff)
      else $error("high clamp does not match out_high");

endmodule

`default_nettype wire

// ===== src/rpc_div.sv =====
// Signed divider, restoring, four quotient bits per step, truncating toward zero.
`default_nettype none

module rpc_div import rpc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  div_ctrl_type               ctrl,
   input  logic signed [ACC_W-1:0]    dividend,
   input  logic signed [SAMPLE_W-1:0] divisor,
   output logic signed [QUO_W-1:0]    quotient,
   output logic                       last
);

   logic [ACC_W-1:0]    quo_ff;
   logic [ACC_W-1:0]    quo_in;
   logic [SAMPLE_W-1:0] rem_ff;
   logic [SAMPLE_W-1:0] rem_in;
   logic [SAMPLE_W-1:0] dmag_ff;
   logic                neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   // Four dependent compare-subtract steps on 17-bit values.
   always_comb begin
      logic [SAMPLE_W:0] trial;
      logic [ACC_W-1:0]  q;
      logic [SAMPLE_W-1:0] r;
      q = quo_ff;
      r = rem_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {r, q[ACC_W-1]};
         q     = {q[ACC_W-2:0], 1'b0};
         if (trial >= {1'b0, dmag_ff}) begin
            trial = trial - {1'b0, dmag_ff};
            q[0]  = 1'b1;
         end
         r = trial[SAMPLE_W-1:0];
      end
      quo_in = q;
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.init) begin
         cnt_ff <= '0;
      end else if (ctrl.step) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         quo_ff  <= dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
         rem_ff  <= '0;
         dmag_ff <= divisor[SAMPLE_W-1] ? (~divisor + 1'b1) : divisor;
         neg_ff  <= dividend[ACC_W-1] ^ divisor[SAMPLE_W-1];
      end else if (ctrl.step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign last     = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

`default_nettype wire

// ===== tb/sv/rst_polynomial_controller_core_test.sv =====
// Self-checking testbench of the RST polynomial controller core with a built-in predictor.
module rst_polynomial_controller_core_test import rpc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ORDER            = 2;
   localparam int RESET_CYCLES     = 7;
   // Cycles waited after the last result so the core can settle.
   localparam int SETTLE_CYCLES    = 3 * ORDER + 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PHASES    = 8;
   localparam int WORDS_PER_HALF   = 125;

   // Register indexes past the last defined register; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct packed {
      logic [15:0] measurement;
      logic [15:0] setpoint;
   } sample_word_type;

   typedef struct packed {
      logic [15:0] control;
      clamp_type   clamped;
      logic        divide_error;
   } control_result_type;

   logic clock = 1'b0;
   logic reset;

   rpc_req_if req_bus ();
   rpc_rsp_if rsp_bus ();
   rpc_csr_if csr_bus ();

   rst_polynomial_controller_core #(
      .ORDER (ORDER)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Words waiting to be offered, and control results waiting to come back.
   sample_word_type    sample_words [$];
   control_result_type expected_controls [$];
   control_result_type oldest_result;
   sample_word_type    next_word;
   logic               word_on_bus = 1'b0;

   int error_count       = 0;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_trigger      = 0;
   int hold_served;
   int rsp_hold_left;
   int stall_cycles;

   // Predictor copy of the configuration, at its reset values.
   logic [47:0]        s_taps    = '0;
   logic [47:0]        t_taps    = '0;
   logic [31:0]        r_taps    = '0;
   logic signed [15:0] r0_div    = 16'sh1000;
   logic signed [15:0] u_floor   = 16'sh0000;
   logic signed [15:0] u_ceiling = 16'sd5120;

   // Predictor copy of the sample histories; index 0 holds the newest past word.
   logic signed [15:0] y_hist [ORDER] = '{default: '0};
   logic signed [15:0] w_hist [ORDER] = '{default: '0};
   logic signed [15:0] u_hist [ORDER] = '{default: '0};

   // The clock runs freely; reset is held at the start and then released.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $realtime, what);
      error_count++;
   endtask

   // One signed Q4.12 tap out of a register packed 16 bits per tap.
   function automatic longint coef_at(input logic [47:0] packed_taps, input int slot);
      return longint'($signed(packed_taps[16*slot +: 16]));
   endfunction

   // Works out the control result of one accepted word and advances the histories.
   function automatic void predict_control(input logic signed [15:0] y,
                                           input logic signed [15:0] w);
      longint             acc;
      longint             u;
      control_result_type res;
      int                 i;
      acc = coef_at(t_taps, 0) * longint'(w) - coef_at(s_taps, 0) * longint'(y);
      for (i = 0; i < ORDER; i++) begin
         acc += coef_at(t_taps, i + 1) * longint'(w_hist[i]);
         acc -= coef_at(s_taps, i + 1) * longint'(y_hist[i]);
         acc -= coef_at({16'h0, r_taps}, i) * longint'(u_hist[i]);
      end
      res.clamped      = CLAMP_NONE;
      res.divide_error = 1'b0;
      if (r0_div == 0) begin
         u                = 0;
         res.divide_error = 1'b1;
      end else begin
         // Integer division truncates toward zero, as the core's divider must.
         u = acc / longint'(r0_div);
         // With crossed limits the low limit wins.
         if (u < longint'(u_floor)) begin
            u           = u_floor;
            res.clamped = CLAMP_LOW;
         end else if (u > longint'(u_ceiling)) begin
            u           = u_ceiling;
            res.clamped = CLAMP_HIGH;
         end
      end
      res.control = u[15:0];
      for (i = ORDER - 1; i > 0; i--) begin
         y_hist[i] = y_hist[i-1];
         w_hist[i] = w_hist[i-1];
         u_hist[i] = u_hist[i-1];
      end
      y_hist[0] = y;
      w_hist[0] = w;
      u_hist[0] = u[15:0];
      expected_controls.push_back(res);
   endfunction

   // Request driver: a word stays on the bus until the core takes it, and the next
   // one is offered in the same edge unless the sender decides to idle.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.measurement <= '0;
         req_bus.setpoint    <= '0;
         word_on_bus = 1'b0;
      end else begin
         if (word_on_bus && req_bus.ready) begin
            predict_control(req_bus.measurement, req_bus.setpoint);
            word_on_bus = 1'b0;
         end
         if (!word_on_bus) begin
            if (sample_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_word = sample_words.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.measurement <= next_word.measurement;
               req_bus.setpoint    <= next_word.setpoint;
               word_on_bus = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started each time the stimulus bumps hold_trigger.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold_left <= 0;
         hold_served   <= 0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (hold_served != hold_trigger) begin
         rsp_hold_left <= LONG_HOLD_CYCLES;
         hold_served   <= hold_trigger;
      end
   end

   // Result monitor: every accepted word is checked field by field against the
   // oldest prediction; ready is lowered at random or during a long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_controls.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected: control %h",
                                         rsp_bus.control));
            end else begin
               oldest_result = expected_controls.pop_front();
               if (rsp_bus.control !== oldest_result.control)
                  report_mismatch($sformatf("control %h, expected %h",
                                            rsp_bus.control, oldest_result.control));
               if (rsp_bus.clamped !== oldest_result.clamped)
                  report_mismatch($sformatf("clamped %0d, expected %0d",
                                            rsp_bus.clamped, oldest_result.clamped));
               if (rsp_bus.divide_error !== oldest_result.divide_error)
                  report_mismatch($sformatf("divide_error %b, expected %b",
                                            rsp_bus.divide_error,
                                            oldest_result.divide_error));
            end
         end
         rsp_bus.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog: ends the run when no channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset) begin
         stall_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Writes one register and mirrors the write into the predictor once it is taken.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [47:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_S_COEFS:      s_taps    = data;
         CSR_T_COEFS:      t_taps    = data;
         CSR_R_TAIL_COEFS: r_taps    = data[31:0];
         CSR_R_LEAD:       r0_div    = data[15:0];
         CSR_OUT_LOW:      u_floor   = data[15:0];
         CSR_OUT_HIGH:     u_ceiling = data[15:0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // Narrow registers get random upper bits, which the core must drop.
   task automatic write_all(input logic [47:0] s, input logic [47:0] t, input logic [31:0] r,
                            input logic [15:0] lead, input logic [15:0] lo,
                            input logic [15:0] hi);
      csr_write(CSR_S_COEFS, s);
      csr_write(CSR_T_COEFS, t);
      csr_write(CSR_R_TAIL_COEFS, {16'($urandom), r});
      csr_write(CSR_R_LEAD, {32'($urandom), lead});
      csr_write(CSR_OUT_LOW, {32'($urandom), lo});
      csr_write(CSR_OUT_HIGH, {32'($urandom), hi});
   endtask

   function automatic void push_word(input logic [15:0] y, input logic [15:0] w);
      sample_word_type sw;
      sw.measurement = y;
      sw.setpoint    = w;
      sample_words.push_back(sw);
   endfunction

   // Waits until every word is sent and every predicted result has come, then lets the
   // core run out its pipeline before anything is reconfigured.
   task automatic wait_for_results();
      while (sample_words.size() != 0 || word_on_bus || expected_controls.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Samples: mostly moderate values so the loop stays inside its limits,
   // with full-scale extremes and fully random words mixed in.
   function automatic logic [15:0] random_sample();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2, 3:    return 16'($urandom);
         default: return 16'($urandom_range(5120) - 2560);
      endcase
   endfunction

   function automatic logic [15:0] random_coef();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'($urandom);
         default: return 16'($urandom_range(8192) - 4096);
      endcase
   endfunction

   function automatic logic [15:0] random_lead();
      case ($urandom_range(7))
         0:       return 16'h1000;
         1:       return 16'($urandom_range(32) - 16);
         2:       return 16'h8000;
         3:       return 16'h7FFF;
         4:       return 16'($urandom);
         default: return 16'($urandom_range(6144) + 1024);
      endcase
   endfunction

   // One random setting per phase; one phase runs with a zero divisor and the
   // limits are sometimes full range, sometimes narrow and sometimes crossed.
   task automatic write_random_config(input int phase);
      logic [15:0] lead;
      int          lo;
      int          hi;
      lead = (phase == 4) ? 16'h0000 : random_lead();
      case ($urandom_range(3))
         0: begin
            lo = -32768;
            hi = 32767;
         end
         1: begin
            lo = $urandom_range(5000);
            hi = -$urandom_range(5000);
         end
         default: begin
            lo = $urandom_range(20000) - 20000;
            hi = $urandom_range(20000);
         end
      endcase
      write_all({random_coef(), random_coef(), random_coef()},
                {random_coef(), random_coef(), random_coef()},
                {random_coef(), random_coef()}, lead, 16'(lo), 16'(hi));
   endtask

   initial begin : stimulus
      int phase;
      int n;
      csr_bus.valid     <= 1'b0;
      csr_bus.index     <= '0;
      csr_bus.data      <= '0;
      sender_idle_pct   = 21;
      receiver_idle_pct = 50;
      do @(posedge clock); while (reset);

      // Reset configuration: all coefficients zero, so the control stays at zero.
      push_word(16'h7FFF, 16'h8000);
      push_word(16'h8000, 16'h7FFF);
      wait_for_results();

      // Known coefficients, full-range limits: full-scale samples drive the
      // output into both clamps and exercise every history tap.
      write_all({16'hFC00, 16'h0800, 16'h1000}, {16'h0400, 16'h0800, 16'h1000},
                {16'hF000, 16'h0800}, 16'h1000, 16'h8000, 16'h7FFF);
      push_word(16'h0000, 16'h0000);
      push_word(16'h7FFF, 16'h8000);
      push_word(16'h8000, 16'h7FFF);
      push_word(16'h7FFF, 16'h7FFF);
      push_word(16'h8000, 16'h8000);
      push_word(16'h0100, 16'h0200);
      push_word(16'hFFFF, 16'h0001);
      push_word(16'h1234, 16'hFA99);
      wait_for_results();

      // An odd divisor leaves remainders, so truncation toward zero shows on
      // negative sums.
      csr_write(CSR_R_LEAD, {32'h0, 16'h0003});
      push_word(16'h0005, 16'hFFF9);
      push_word(16'hFED4, 16'h000B);
      push_word(16'h0001, 16'h0000);
      wait_for_results();

      // Zero divisor: the control is forced to zero and flagged, histories go on.
      csr_write(CSR_R_LEAD, {32'h0, 16'h0000});
      push_word(16'h0064, 16'hFF9C);
      push_word(16'h7FFF, 16'h0001);
      push_word(16'h0000, 16'h7FFF);
      wait_for_results();

      // Writes to spare indexes change nothing. Then the most negative divisor
      // with crossed limits, where the low limit is tested first.
      csr_write(CSR_SPARE_A, {32'($urandom), 16'($urandom)});
      csr_write(CSR_SPARE_B, {32'($urandom), 16'($urandom)});
      csr_write(CSR_R_LEAD, {32'h0, 16'h8000});
      csr_write(CSR_OUT_LOW, {32'h0, 16'h0064});
      csr_write(CSR_OUT_HIGH, {32'h0, 16'hFF9C});
      push_word(16'h0000, 16'h0000);
      push_word(16'h7FFF, 16'h8000);
      push_word(16'h8000, 16'h7FFF);
      push_word(16'h0032, 16'h003C);
      wait_for_results();

      // Random phases: sender idles less than receiver, then the reverse, then
      // neither. Each phase stops midway until every result is back.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 3) begin
            sender_idle_pct   = 50;
            receiver_idle_pct = 21;
         end else if (phase == 6) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_random_config(phase);
         for (n = 0; n < WORDS_PER_HALF; n++) push_word(random_sample(), random_sample());
         wait_for_results();
         for (n = 0; n < WORDS_PER_HALF; n++) push_word(random_sample(), random_sample());
         // The receiver stalls for a long stretch while words keep coming,
         // so the core fills up and has to hold its request side.
         if (phase == 6) hold_trigger++;
         wait_for_results();
      end

      if (expected_controls.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_controls.size()));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/rpc_pkg.sv
src/rpc_if.sv
src/rpc_div.sv
src/rst_polynomial_controller_core.sv
tb/sv/rst_polynomial_controller_core_test.sv
